// ===== rtl/lpdc_pkg.sv =====
package lpdc_pkg;

  // Default lower bound on the PWM period, in ticks
  localparam int unsigned LPDC_MIN_PERIOD = 8;

  localparam logic [31:0] CLOCK_HZ_RESET = 32'd80000000;
  localparam logic [19:0] FREQ_HZ_RESET  = 20'd1000;
  localparam logic [15:0] POWER_MAX_RESET = 16'd1000;

  // Shared serial divider: 48-bit dividend, 20-bit divisor
  localparam int unsigned DivW   = 48;
  localparam int unsigned DvsrW  = 20;
  localparam int unsigned CntW   = 6;
  localparam int unsigned PerDivSteps = 33;
  localparam int unsigned HiDivSteps  = 48;

  typedef enum logic [1:0] {
    CMD_SET_POWER = 2'd0,
    CMD_ENABLE    = 2'd1,
    CMD_FORCE_OFF = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_CLOCK_HZ  = 2'd0,
    CFG_FREQ_HZ   = 2'd1,
    CFG_POWER_MAX = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] power_value;
  } cmd_t;

  typedef struct packed {
    logic        pwm_running;
    logic        pin_forced_low;
    logic        duty_applied;
    logic [31:0] pulse_ticks;
    logic [31:0] low_ticks;
    logic [31:0] frame_ticks;
    logic        enabled_flag;
    logic [15:0] power_setting;
    logic [15:0] requested_power;
    logic [15:0] effective_power;
  } rsp_t;

  // Microcode
  typedef enum logic [3:0] {
    U_WAIT,
    U_DECODE,
    U_LD_PER,
    U_DIV,
    U_ST_PER,
    U_MUL,
    U_ST_HI,
    U_OUT,
    U_NOP
  } uop_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_SKIP,
    C_DIV_BUSY,
    C_OUT_FULL
  } cond_e;

  typedef logic [3:0] step_t;

  typedef struct packed {
    uop_e  op;
    cond_e cond;
    step_t target;
  } uword_t;

  localparam step_t StepWait = 4'd0;
  localparam step_t StepDivPer = 4'd3;
  localparam step_t StepDivHi = 4'd6;
  localparam step_t StepOut  = 4'd8;

  // Control store: jump to target when cond holds, else fall through
  function automatic uword_t lpdc_ucode(step_t step);
    uword_t w;
    unique case (step)
      4'd0:    w = '{op: U_WAIT,   cond: C_NO_INPUT, target: StepWait};
      4'd1:    w = '{op: U_DECODE, cond: C_SKIP,     target: StepOut};
      4'd2:    w = '{op: U_LD_PER, cond: C_NEVER,    target: StepWait};
      4'd3:    w = '{op: U_DIV,    cond: C_DIV_BUSY, target: StepDivPer};
      4'd4:    w = '{op: U_ST_PER, cond: C_NEVER,    target: StepWait};
      4'd5:    w = '{op: U_MUL,    cond: C_NEVER,    target: StepWait};
      4'd6:    w = '{op: U_DIV,    cond: C_DIV_BUSY, target: StepDivHi};
      4'd7:    w = '{op: U_ST_HI,  cond: C_NEVER,    target: StepWait};
      4'd8:    w = '{op: U_OUT,    cond: C_OUT_FULL, target: StepOut};
      default: w = '{op: U_NOP,    cond: C_ALWAYS,   target: StepWait};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/lpdc_intf.sv =====
interface lpdc_cmd_if;
  import lpdc_pkg::*;
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lpdc_rsp_if;
  import lpdc_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lpdc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  idx;
  logic [31:0] wdata;
  modport source (output valid, output idx, output wdata, input ready);
  modport sink (input valid, input idx, input wdata, output ready);
endinterface

// ===== rtl/laser_pwm_duty_controller.sv =====
// Laser PWM duty controller.
// cfg_i: register writes (clock Hz, PWM frequency Hz, full-scale power), always
//   ready; write only while no command is in flight.
// cmd_i: set-power / enable / force-off commands. cmd_i.ready is high only while
//   the sequencer waits at its idle step; one command is processed at a time.
// rsp_o: exactly one result per command, held in an output register until taken.
// Per command: when nothing is recomputed (force-off, ignored code, unchanged
//   setting) the sequencer goes from decode straight to the output step; when
//   the duty is recomputed it runs the shared one-bit-per-cycle divider twice,
//   33 steps for round(clock / freq) and 48 steps for power * period /
//   power_max, before it stores the duty and outputs the result.
// A result waits in the output register while the receiver stalls; the next
//   command is still accepted and runs until it needs the output register.
// Reset: config registers return to 80 MHz / 1 kHz / 1000, all laser state
//   clears, no result is pending.
module laser_pwm_duty_controller import lpdc_pkg::*; #(
  parameter int unsigned MIN_PERIOD = LPDC_MIN_PERIOD
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  lpdc_cfg_if.sink         cfg_i,
  lpdc_cmd_if.sink         cmd_i,
  lpdc_rsp_if.source       rsp_o
);

  localparam logic [31:0] MinPer = 32'(MIN_PERIOD);

  // config
  logic [31:0] clk_hz_q, clk_hz_d;
  logic [19:0] freq_q, freq_d;
  logic [15:0] pmax_q, pmax_d;

  // sequencer
  step_t  pc_q, pc_d;
  uword_t uw;

  // captured command
  logic [1:0]  cmd_q, cmd_d;
  logic [15:0] pv_q, pv_d;

  // laser state
  logic        enabled_q, enabled_d;
  logic [15:0] power_q, power_d;
  logic        open_q, open_d;
  logic        av_q, av_d;
  logic [31:0] ah_q, ah_d;
  logic [31:0] al_q, al_d;
  logic [31:0] last_per_q, last_per_d;
  logic [31:0] last_hi_q, last_hi_d;
  logic [31:0] last_lo_q, last_lo_d;
  logic [15:0] last_req_q, last_req_d;
  logic [15:0] last_eff_q, last_eff_d;
  logic        forced_q, forced_d;
  logic        duty_q, duty_d;

  // divider
  logic [DivW-1:0]  quo_q, quo_d;
  logic [DvsrW-1:0] rem_q, rem_d;
  logic [DvsrW-1:0] dvsr_q, dvsr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  // output register
  logic rsp_valid_q, rsp_valid_d;
  rsp_t rsp_q, rsp_d;

  logic [15:0]     pv_clamp;
  logic [15:0]     p_out;
  logic            need_upd;
  logic            cond_hit;
  logic [DvsrW:0]  shifted;
  logic [DvsrW:0]  diff;
  logic            ge;
  logic [32:0]     per_num;
  logic [DvsrW-1:0] freq_eff;
  logic [31:0]     per_q33;
  logic [DivW-1:0] prod;
  logic [31:0]     hi_calc;
  logic [31:0]     lo_calc;
  logic            same_pair;
  logic            rsp_full;

  assign uw = lpdc_ucode(pc_q);

  assign cfg_i.ready = 1'b1;
  assign cmd_i.ready = (uw.op == U_WAIT);
  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;
  assign rsp_full    = rsp_valid_q && !rsp_o.ready;

  assign pv_clamp = (pv_q > pmax_q) ? pmax_q : pv_q;
  assign p_out    = enabled_q ? power_q : 16'd0;

  always_comb begin
    unique case (cmd_e'(cmd_q))
      CMD_SET_POWER: need_upd = !((pv_clamp == power_q) &&
                                  (!enabled_q || (pv_clamp == 16'd0) || open_q));
      CMD_ENABLE:    need_upd = !(enabled_q && ((power_q == 16'd0) || open_q));
      default:       need_upd = 1'b0;
    endcase
  end

  // divider step
  assign shifted = {rem_q, quo_q[DivW-1]};
  assign diff    = shifted - {1'b0, dvsr_q};
  assign ge      = (shifted >= {1'b0, dvsr_q});

  assign freq_eff = (freq_q == '0) ? DvsrW'(1) : freq_q;
  assign per_num  = {1'b0, clk_hz_q} + {14'd0, freq_q[19:1]};
  assign per_q33  = quo_q[31:0];
  assign prod     = DivW'(p_out) * DivW'(last_per_q);

  always_comb begin
    if (p_out == 16'd0) begin
      hi_calc = 32'd0;
    end else if ((pmax_q == 16'd0) || (quo_q == '0)) begin
      hi_calc = 32'd1;
    end else if (quo_q >= {16'd0, last_per_q}) begin
      hi_calc = last_per_q - 32'd1;
    end else begin
      hi_calc = quo_q[31:0];
    end
  end
  assign lo_calc   = last_per_q - hi_calc;
  assign same_pair = av_q && (ah_q == hi_calc) && (al_q == lo_calc);

  // step counter
  always_comb begin
    unique case (uw.cond)
      C_NEVER:    cond_hit = 1'b0;
      C_ALWAYS:   cond_hit = 1'b1;
      C_NO_INPUT: cond_hit = !cmd_i.valid;
      C_SKIP:     cond_hit = !need_upd;
      C_DIV_BUSY: cond_hit = (cnt_q != CntW'(1));
      C_OUT_FULL: cond_hit = rsp_full;
      default:    cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    pc_d = cond_hit ? uw.target : step_t'(pc_q + step_t'(1));
  end

  // datapath controlled by the current control word
  always_comb begin
    clk_hz_d   = clk_hz_q;
    freq_d     = freq_q;
    pmax_d     = pmax_q;
    cmd_d      = cmd_q;
    pv_d       = pv_q;
    enabled_d  = enabled_q;
    power_d    = power_q;
    open_d     = open_q;
    av_d       = av_q;
    ah_d       = ah_q;
    al_d       = al_q;
    last_per_d = last_per_q;
    last_hi_d  = last_hi_q;
    last_lo_d  = last_lo_q;
    last_req_d = last_req_q;
    last_eff_d = last_eff_q;
    forced_d   = forced_q;
    duty_d     = duty_q;
    quo_d      = quo_q;
    rem_d      = rem_q;
    dvsr_d     = dvsr_q;
    cnt_d      = cnt_q;
    rsp_d      = rsp_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;

    if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.idx))
        CFG_CLOCK_HZ:  clk_hz_d = cfg_i.wdata;
        CFG_FREQ_HZ:   freq_d   = cfg_i.wdata[19:0];
        CFG_POWER_MAX: pmax_d   = cfg_i.wdata[15:0];
        default: ;
      endcase
    end

    unique case (uw.op)
      U_WAIT: begin
        if (cmd_i.valid) begin
          cmd_d = cmd_i.data.command;
          pv_d  = cmd_i.data.power_value;
        end
      end
      U_DECODE: begin
        forced_d = 1'b0;
        duty_d   = 1'b0;
        unique case (cmd_e'(cmd_q))
          CMD_SET_POWER: begin
            last_req_d = pv_q;
            power_d    = pv_clamp;
          end
          CMD_ENABLE: begin
            if (need_upd) enabled_d = 1'b1;
          end
          CMD_FORCE_OFF: begin
            enabled_d = 1'b0;
            power_d   = 16'd0;
            open_d    = 1'b0;
            av_d      = 1'b0;
            forced_d  = 1'b1;
          end
          default: ;
        endcase
      end
      U_LD_PER: begin
        quo_d  = {per_num, 15'd0};
        rem_d  = '0;
        dvsr_d = freq_eff;
        cnt_d  = CntW'(PerDivSteps);
      end
      U_DIV: begin
        quo_d = {quo_q[DivW-2:0], ge};
        rem_d = ge ? diff[DvsrW-1:0] : shifted[DvsrW-1:0];
        cnt_d = cnt_q - CntW'(1);
      end
      U_ST_PER: begin
        last_per_d = (per_q33 < MinPer) ? MinPer : per_q33;
      end
      U_MUL: begin
        quo_d  = prod;
        rem_d  = '0;
        dvsr_d = {4'd0, pmax_q};
        cnt_d  = CntW'(HiDivSteps);
      end
      U_ST_HI: begin
        last_hi_d  = hi_calc;
        last_lo_d  = lo_calc;
        last_eff_d = p_out;
        if (open_q) begin
          if (!same_pair) begin
            ah_d   = hi_calc;
            al_d   = lo_calc;
            av_d   = 1'b1;
            duty_d = 1'b1;
          end
        end else if (p_out == 16'd0) begin
          forced_d = 1'b1;
        end else begin
          open_d = 1'b1;
          ah_d   = hi_calc;
          al_d   = lo_calc;
          av_d   = 1'b1;
          duty_d = 1'b1;
        end
      end
      U_OUT: begin
        if (!rsp_full) begin
          rsp_valid_d           = 1'b1;
          rsp_d.pwm_running     = open_q;
          rsp_d.pin_forced_low  = forced_q;
          rsp_d.duty_applied    = duty_q;
          rsp_d.pulse_ticks     = last_hi_q;
          rsp_d.low_ticks       = last_lo_q;
          rsp_d.frame_ticks     = last_per_q;
          rsp_d.enabled_flag    = enabled_q;
          rsp_d.power_setting   = power_q;
          rsp_d.requested_power = last_req_q;
          rsp_d.effective_power = last_eff_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q    <= CLOCK_HZ_RESET;
      freq_q      <= FREQ_HZ_RESET;
      pmax_q      <= POWER_MAX_RESET;
      pc_q        <= StepWait;
      enabled_q   <= 1'b0;
      power_q     <= '0;
      open_q      <= 1'b0;
      av_q        <= 1'b0;
      ah_q        <= '0;
      al_q        <= '0;
      last_per_q  <= '0;
      last_hi_q   <= '0;
      last_lo_q   <= '0;
      last_req_q  <= '0;
      last_eff_q  <= '0;
      forced_q    <= 1'b0;
      duty_q      <= 1'b0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      clk_hz_q    <= clk_hz_d;
      freq_q      <= freq_d;
      pmax_q      <= pmax_d;
      pc_q        <= pc_d;
      enabled_q   <= enabled_d;
      power_q     <= power_d;
      open_q      <= open_d;
      av_q        <= av_d;
      ah_q        <= ah_d;
      al_q        <= al_d;
      last_per_q  <= last_per_d;
      last_hi_q   <= last_hi_d;
      last_lo_q   <= last_lo_d;
      last_req_q  <= last_req_d;
      last_eff_q  <= last_eff_d;
      forced_q    <= forced_d;
      duty_q      <= duty_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    pv_q   <= pv_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
    rsp_q  <= rsp_d;
  end

endmodule

// ===== rtl/lpdc_checker.sv =====
module lpdc_checker import lpdc_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic cmd_valid_i,
  input logic cmd_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input rsp_t rsp_data_i
);

  // one command in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("command accepted while another is in flight");

  // a stalled result holds until taken
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i))
    else $error("result transaction changed while stalled");

  a_duty_needs_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.duty_applied |-> rsp_data_i.pwm_running)
    else $error("duty loaded while PWM closed");

  a_forced_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_data_i.pin_forced_low |-> !rsp_data_i.pwm_running)
    else $error("pin forced low while PWM running");

  a_ticks_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |->
      (32'(rsp_data_i.pulse_ticks + rsp_data_i.low_ticks) == rsp_data_i.frame_ticks))
    else $error("high plus low ticks differ from period");

endmodule

bind laser_pwm_duty_controller lpdc_checker u_lpdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cmd_valid_i (cmd_i.valid),
  .cmd_ready_i (cmd_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

// ===== tb/tb_laser_pwm_duty_controller.sv =====
module tb_laser_pwm_duty_controller import lpdc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CmdUnused = 2'd3;
  localparam logic [1:0] CfgUnused = 2'd3;
  localparam int unsigned WatchdogLimit = 4000;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  lpdc_cfg_if cfg_if ();
  lpdc_cmd_if cmd_if ();
  lpdc_rsp_if rsp_if ();

  laser_pwm_duty_controller dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  // Duty predictor state, mirrors the block after reset
  logic [31:0] cfg_clock = CLOCK_HZ_RESET;
  logic [19:0] cfg_freq = FREQ_HZ_RESET;
  logic [15:0] cfg_pmax = POWER_MAX_RESET;
  logic        laser_en = 1'b0;
  logic [15:0] laser_power = '0;
  logic        pwm_open = 1'b0;
  logic        duty_valid = 1'b0;
  logic [31:0] duty_high = '0;
  logic [31:0] duty_low = '0;
  logic [31:0] period_now = '0;
  logic [31:0] high_now = '0;
  logic [31:0] low_now = '0;
  logic [15:0] req_power = '0;
  logic [15:0] eff_power = '0;
  logic        flag_forced_low;
  logic        flag_duty;

  rsp_t pending_rsp[$];
  int   fail_count = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   hold_left = 0;
  int   stall_burst = 0;
  int   quiet_cycles = 0;
  bit   cmd_offered = 1'b0;

  // Recompute period and duty for the output power, then load or force low
  function automatic void refresh_duty();
    logic [15:0] p;
    logic [63:0] freq;
    logic [63:0] per;
    logic [63:0] hi;
    p = laser_en ? laser_power : 16'd0;
    freq = (cfg_freq == '0) ? 64'd1 : 64'(cfg_freq);
    per = (64'(cfg_clock) + freq / 64'd2) / freq;
    if (per < 64'(LPDC_MIN_PERIOD)) per = 64'(LPDC_MIN_PERIOD);
    if (per > 64'hFFFF_FFFF) per = 64'hFFFF_FFFF;
    hi = (cfg_pmax != '0) ? (64'(p) * per) / 64'(cfg_pmax) : 64'd0;
    if (p == '0) hi = 64'd0;
    else if (hi == 64'd0) hi = 64'd1;
    else if (hi >= per) hi = per - 64'd1;
    period_now = per[31:0];
    high_now = hi[31:0];
    low_now = 32'(per - hi);
    eff_power = p;
    if (pwm_open) begin
      if (!(duty_valid && duty_high == high_now && duty_low == low_now)) begin
        duty_high = high_now;
        duty_low = low_now;
        duty_valid = 1'b1;
        flag_duty = 1'b1;
      end
    end else if (p == '0) begin
      flag_forced_low = 1'b1;
    end else begin
      pwm_open = 1'b1;
      duty_high = high_now;
      duty_low = low_now;
      duty_valid = 1'b1;
      flag_duty = 1'b1;
    end
  endfunction

  function automatic rsp_t laser_step(input cmd_t c);
    rsp_t r;
    logic [15:0] pv;
    logic [15:0] outp;
    flag_forced_low = 1'b0;
    flag_duty = 1'b0;
    pv = c.power_value;
    case (c.command)
      CMD_SET_POWER: begin
        req_power = pv;
        if (pv > cfg_pmax) pv = cfg_pmax;
        outp = laser_en ? pv : 16'd0;
        // unchanged setting only reopens a closed channel with nonzero output
        if (pv != laser_power || !(outp == '0 || pwm_open)) begin
          laser_power = pv;
          refresh_duty();
        end
      end
      CMD_ENABLE: begin
        if (!(laser_en && (laser_power == '0 || pwm_open))) begin
          laser_en = 1'b1;
          refresh_duty();
        end
      end
      CMD_FORCE_OFF: begin
        laser_en = 1'b0;
        laser_power = '0;
        pwm_open = 1'b0;
        duty_valid = 1'b0;
        flag_forced_low = 1'b1;
      end
      default: ;
    endcase
    r.pwm_running = pwm_open;
    r.pin_forced_low = flag_forced_low;
    r.duty_applied = flag_duty;
    r.pulse_ticks = high_now;
    r.low_ticks = low_now;
    r.frame_ticks = period_now;
    r.enabled_flag = laser_en;
    r.power_setting = laser_power;
    r.requested_power = req_power;
    r.effective_power = eff_power;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    rsp_t want;
    rsp_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (pending_rsp.size() == 0) begin
        $error("result transaction with no command pending");
        fail_count++;
      end else begin
        want = pending_rsp.pop_front();
        check_field("pwm_running", want.pwm_running, got.pwm_running);
        check_field("pin_forced_low", want.pin_forced_low, got.pin_forced_low);
        check_field("duty_applied", want.duty_applied, got.duty_applied);
        check_field("pulse_ticks", want.pulse_ticks, got.pulse_ticks);
        check_field("low_ticks", want.low_ticks, got.low_ticks);
        check_field("frame_ticks", want.frame_ticks, got.frame_ticks);
        check_field("enabled_flag", want.enabled_flag, got.enabled_flag);
        check_field("power_setting", want.power_setting, got.power_setting);
        check_field("requested_power", want.requested_power, got.requested_power);
        check_field("effective_power", want.effective_power, got.effective_power);
      end
    end
  end

  // Receiver: long hold-off, random stall bursts, or always ready
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else if (stall_burst > 0) begin
      stall_burst--;
      rsp_if.ready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      if ($urandom_range(0, 15) == 0) stall_burst = $urandom_range(1, 120);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // valid stays up between back-to-back commands; it only drops when time passes idle
  task automatic send_cmd(input logic [1:0] op, input logic [15:0] pv);
    cmd_t c;
    if (send_idle_pct != 0) begin
      if (cmd_offered && $urandom_range(0, 99) < send_idle_pct) begin
        cmd_if.valid <= 1'b0;
        cmd_offered = 1'b0;
        if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 120)) @(posedge clk_i);
        else @(posedge clk_i);
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
        cmd_if.valid <= 1'b0;
        cmd_offered = 1'b0;
        @(posedge clk_i);
      end
    end
    c.command = op;
    c.power_value = pv;
    cmd_if.valid <= 1'b1;
    cmd_if.data <= c;
    cmd_offered = 1'b1;
    do @(posedge clk_i); while (!cmd_if.ready);
    pending_rsp.push_back(laser_step(c));
  endtask

  task automatic wait_results_done();
    if (cmd_offered) begin
      cmd_if.valid <= 1'b0;
      cmd_offered = 1'b0;
    end
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.idx <= idx;
    cfg_if.wdata <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_CLOCK_HZ:  cfg_clock = val;
      CFG_FREQ_HZ:   cfg_freq = val[19:0];
      CFG_POWER_MAX: cfg_pmax = val[15:0];
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reconfigure(input logic [31:0] clk_hz, input logic [31:0] freq_hz,
                             input logic [31:0] pmax);
    wait_results_done();
    repeat (4) @(posedge clk_i);
    write_reg(CFG_CLOCK_HZ, clk_hz);
    write_reg(CFG_FREQ_HZ, freq_hz);
    write_reg(CFG_POWER_MAX, pmax);
  endtask

  task automatic test_power_sequencing();
    send_cmd(CmdUnused, 16'hFFFF);
    send_cmd(CMD_SET_POWER, 16'd0);
    send_cmd(CMD_ENABLE, 16'd0);       // zero power while closed: pin low
    send_cmd(CMD_ENABLE, 16'd0);
    send_cmd(CMD_SET_POWER, 16'd500);  // opens the channel
    send_cmd(CMD_SET_POWER, 16'd500);
    send_cmd(CMD_SET_POWER, 16'hFFFF); // clamps to full scale
    send_cmd(CMD_SET_POWER, 16'd1);
    send_cmd(CMD_ENABLE, 16'd0);
    send_cmd(CMD_SET_POWER, 16'd0);
    send_cmd(CMD_FORCE_OFF, 16'h5555);
    send_cmd(CMD_SET_POWER, 16'd700);
    send_cmd(CMD_SET_POWER, 16'd700);
    send_cmd(CMD_ENABLE, 16'hAAAA);
    send_cmd(CMD_FORCE_OFF, 16'd0);
  endtask

  task automatic test_config_corners();
    reconfigure(32'hFFFF_FFFF, 32'd1, 32'd65535);
    send_cmd(CMD_ENABLE, 16'd0);
    send_cmd(CMD_SET_POWER, 16'hFFFF);
    send_cmd(CMD_SET_POWER, 16'h8000);
    send_cmd(CMD_SET_POWER, 16'd1);
    // zero clock, zero frequency, zero full scale
    reconfigure(32'd0, 32'd0, 32'd0);
    write_reg(CfgUnused, 32'hFFFF_FFFF);
    send_cmd(CMD_SET_POWER, 16'd1000);
    send_cmd(CMD_SET_POWER, 16'd5);
    reconfigure(32'd10, 32'h000F_FFFF, 32'd1);
    send_cmd(CMD_SET_POWER, 16'd1);
    reconfigure(32'd80_000_000, 32'd1_000_000, 32'd65535);
    send_cmd(CMD_FORCE_OFF, 16'd0);
    send_cmd(CMD_SET_POWER, 16'hFFFF);
    // setting above the new full scale
    reconfigure(32'd80_000_000, 32'd1_000_000, 32'd100);
    send_cmd(CMD_ENABLE, 16'd0);
  endtask

  task automatic test_output_backpressure();
    reconfigure(CLOCK_HZ_RESET, 32'(FREQ_HZ_RESET), 32'(POWER_MAX_RESET));
    send_idle_pct = 0;
    stall_pct = 0;
    send_cmd(CMD_ENABLE, 16'd0);
    hold_left = 400;
    for (int i = 0; i < 10; i++) send_cmd(CMD_SET_POWER, 16'(i * 97 + 3));
    wait_results_done();
    send_cmd(CMD_SET_POWER, 16'd999);
    send_cmd(CMD_FORCE_OFF, 16'd0);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall, input int n);
    int sent;
    int next_cfg;
    int pick;
    logic [1:0] op;
    logic [15:0] pv;
    logic [31:0] clk_hz;
    logic [19:0] freq;
    logic [15:0] pmax;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    sent = 0;
    next_cfg = 0;
    while (sent < n) begin
      if (sent >= next_cfg) begin
        next_cfg += 150;
        case ($urandom_range(0, 6))
          0:       clk_hz = 32'd0;
          1:       clk_hz = 32'($urandom_range(1, 200));
          2:       clk_hz = 32'd80_000_000;
          3:       clk_hz = $urandom;
          4:       clk_hz = 32'hFFFF_FFFF;
          default: clk_hz = 32'($urandom_range(1000, 100_000_000));
        endcase
        case ($urandom_range(0, 6))
          0:       freq = 20'd0;
          1:       freq = 20'd1;
          2:       freq = 20'd1_000_000;
          3:       freq = 20'hFFFFF;
          4:       freq = 20'($urandom_range(1, 2000));
          default: freq = 20'($urandom_range(1, 1_000_000));
        endcase
        case ($urandom_range(0, 6))
          0:       pmax = 16'd0;
          1:       pmax = 16'd1;
          2:       pmax = 16'hFFFF;
          3:       pmax = 16'd1000;
          4:       pmax = 16'($urandom_range(1, 255));
          default: pmax = 16'($urandom_range(1, 65535));
        endcase
        // upper write-data bits of the narrow registers are don't-care
        reconfigure(clk_hz, {12'($urandom), freq}, {16'($urandom), pmax});
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) op = CMD_FORCE_OFF;
      else if (pick < 35) op = CMD_ENABLE;
      else if (pick < 40) op = CmdUnused;
      else op = CMD_SET_POWER;
      pv = 16'($urandom);
      if (op == CMD_SET_POWER) begin
        case ($urandom_range(0, 9))
          0: pv = '0;
          1: pv = cfg_pmax;
          2: pv = cfg_pmax + 16'($urandom_range(0, 2)) - 16'd1;
          3: pv = laser_power;
          4: ;
          default: pv = (cfg_pmax == '0) ? pv : 16'($urandom_range(0, cfg_pmax));
        endcase
      end
      send_cmd(op, pv);
      sent++;
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.idx <= CFG_CLOCK_HZ;
    cfg_if.wdata <= '0;
    cmd_if.valid <= 1'b0;
    cmd_if.data <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_power_sequencing();
    test_config_corners();
    test_output_backpressure();
    test_random_traffic(0, 0, 440);
    test_random_traffic(64, 0, 430);
    test_random_traffic(0, 64, 430);
    test_random_traffic(29, 29, 430);
    wait_results_done();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
